// ===== hw/rtl/vara_pkg.sv =====
`timescale 1ns / 1ps

package vara_pkg;

  // Field widths on the stream ports
  localparam int FIELD_W    = 16;
  localparam int IN_FIELDS  = 6;
  localparam int OUT_ELEMS  = 9;
  localparam int IN_DATA_W  = FIELD_W * IN_FIELDS;
  localparam int OUT_DATA_W = FIELD_W * OUT_ELEMS;

  // K^2 of a skew matrix is symmetric: six distinct elements, one divider lane each
  localparam int LANES = 6;
  localparam int L00 = 0;
  localparam int L01 = 1;
  localparam int L02 = 2;
  localparam int L11 = 3;
  localparam int L12 = 4;
  localparam int L22 = 5;

  // Output saturation limits
  localparam logic signed [FIELD_W-1:0] SAT_MAX = 16'sh7FFF;
  localparam logic signed [FIELD_W-1:0] SAT_MIN = 16'sh8000;

  typedef logic signed [FIELD_W-1:0] field_t;

endpackage

// ===== hw/rtl/vara_front.sv =====
`timescale 1ns / 1ps

// Front end: products, rounded K, denominator, K^2 and divider operands.
module vara_front #(
  parameter int FRAC_BITS = 14,
  parameter int KW        = 19,
  parameter int DW        = 34,
  parameter int NW        = 52,
  parameter int QW        = 22,
  parameter int SBW       = 70
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  vara_pkg::field_t      ax,
  input  vara_pkg::field_t      ay,
  input  vara_pkg::field_t      az,
  input  vara_pkg::field_t      bx,
  input  vara_pkg::field_t      by_comp,
  input  vara_pkg::field_t      bz,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [DW-1:0]         rem_o [vara_pkg::LANES],
  output logic [QW-1:0]         low_o [vara_pkg::LANES],
  output logic [DW-1:0]         div_o,
  output logic [SBW-1:0]        sb_o
);
  import vara_pkg::*;

  localparam int NST = 4;
  localparam int KSW = 2 * KW + 1;
  localparam int CW  = (NW > DW + QW) ? NW : DW + QW;

  logic [NST-1:0] vld_r;
  logic [NST-1:0] adv;

  // Stage handshake: a stage loads when empty or when the next one moves
  always_comb begin
    adv[NST-1] = !vld_r[NST-1] || out_ready;
    for (int s = NST - 2; s >= 0; s--) begin
      adv[s] = !vld_r[s] || adv[s+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) vld_r[0] <= in_valid;
      for (int s = 1; s < NST; s++) begin
        if (adv[s]) vld_r[s] <= vld_r[s-1];
      end
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = vld_r[NST-1];

  // Round a Q(2F) value to QF, ties away from zero
  function automatic logic signed [KW-1:0] rnd(input logic signed [32:0] d);
    logic [32:0] mag;
    logic [32:0] sh;
    mag = d[32] ? 33'(-d) : 33'(d);
    sh  = (mag + (33'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    return d[32] ? -KW'(sh) : KW'(sh);
  endfunction

  // Stage 0: input products
  logic signed [31:0] m_ba01_r, m_ab01_r, m_ba02_r, m_ab02_r, m_ba12_r, m_ab12_r;
  logic signed [31:0] m_d0_r, m_d1_r, m_d2_r;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      m_ba01_r <= bx * ay;
      m_ab01_r <= ax * by_comp;
      m_ba02_r <= bx * az;
      m_ab02_r <= ax * bz;
      m_ba12_r <= by_comp * az;
      m_ab12_r <= ay * bz;
      m_d0_r   <= ax * bx;
      m_d1_r   <= ay * by_comp;
      m_d2_r   <= az * bz;
    end
  end

  // Stage 1: rounded K elements, denominator, singular flag
  logic signed [KW-1:0] k01_r, k02_r, k12_r;
  logic signed [DW-1:0] den_r;
  logic                 sing_r;
  logic signed [33:0]   dot;
  logic signed [DW-1:0] den_nxt;

  always_comb begin
    dot     = 34'(m_d0_r) + 34'(m_d1_r) + 34'(m_d2_r);
    den_nxt = DW'(dot) + (DW'(1) << (2 * FRAC_BITS));
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      k01_r  <= rnd(33'(m_ba01_r) - 33'(m_ab01_r));
      k02_r  <= rnd(33'(m_ba02_r) - 33'(m_ab02_r));
      k12_r  <= rnd(33'(m_ba12_r) - 33'(m_ab12_r));
      den_r  <= den_nxt;
      sing_r <= den_nxt[DW-1] || (den_nxt == '0);
    end
  end

  // Stage 2: products of K elements
  logic signed [2*KW-1:0] pp_r, qq_r, rr_r, qr_r, pr_r, pq_r;
  logic signed [KW-1:0]   k01_2r, k02_2r, k12_2r;
  logic signed [DW-1:0]   den_2r;
  logic                   sing_2r;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      pp_r    <= k01_r * k01_r;
      qq_r    <= k02_r * k02_r;
      rr_r    <= k12_r * k12_r;
      qr_r    <= k02_r * k12_r;
      pr_r    <= k01_r * k12_r;
      pq_r    <= k01_r * k02_r;
      k01_2r  <= k01_r;
      k02_2r  <= k02_r;
      k12_2r  <= k12_r;
      den_2r  <= den_r;
      sing_2r <= sing_r;
    end
  end

  // Stage 3: K^2 elements, sign and magnitude, divider numerator
  logic signed [KSW-1:0] k2   [LANES];
  logic [KSW-1:0]        mag  [LANES];
  logic [NW-1:0]         num  [LANES];
  logic [LANES-1:0]      neg;
  logic [LANES-1:0]      ovf;
  logic [DW-1:0]         dvs;

  always_comb begin
    k2[L00] = -(KSW'(pp_r) + KSW'(qq_r));
    k2[L01] = -KSW'(qr_r);
    k2[L02] = KSW'(pr_r);
    k2[L11] = -(KSW'(pp_r) + KSW'(rr_r));
    k2[L12] = -KSW'(pq_r);
    k2[L22] = -(KSW'(qq_r) + KSW'(rr_r));
    dvs = {den_2r[DW-2:0], 1'b0};
    for (int l = 0; l < LANES; l++) begin
      neg[l] = k2[l][KSW-1];
      mag[l] = neg[l] ? KSW'(-k2[l]) : KSW'(k2[l]);
      num[l] = (NW'(mag[l]) << (FRAC_BITS + 1)) + NW'(unsigned'(den_2r));
      ovf[l] = CW'(num[l]) >= (CW'(dvs) << QW);
    end
  end

  logic [DW-1:0]  rem_r [LANES];
  logic [QW-1:0]  low_r [LANES];
  logic [DW-1:0]  div_r;
  logic [SBW-1:0] sb_r;

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      for (int l = 0; l < LANES; l++) begin
        rem_r[l] <= DW'(num[l] >> QW);
        low_r[l] <= num[l][QW-1:0];
      end
      div_r <= dvs;
      sb_r  <= {sing_2r, ovf, neg, k12_2r, k02_2r, k01_2r};
    end
  end

  assign rem_o = rem_r;
  assign low_o = low_r;
  assign div_o = div_r;
  assign sb_o  = sb_r;

endmodule

// ===== hw/rtl/vara_div.sv =====
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per stage, all lanes share the divisor.
module vara_div #(
  parameter int DW  = 34,
  parameter int QW  = 22,
  parameter int SBW = 70
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [DW-1:0]  rem_i [vara_pkg::LANES],
  input  logic [QW-1:0]  low_i [vara_pkg::LANES],
  input  logic [DW-1:0]  div_i,
  input  logic [SBW-1:0] sb_i,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [QW-1:0]  quo_o [vara_pkg::LANES],
  output logic [SBW-1:0] sb_o
);
  import vara_pkg::*;

  logic [QW-1:0] vld_r;
  logic [QW-1:0] adv;

  always_comb begin
    adv[QW-1] = !vld_r[QW-1] || out_ready;
    for (int s = QW - 2; s >= 0; s--) begin
      adv[s] = !vld_r[s] || adv[s+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) vld_r[0] <= in_valid;
      for (int s = 1; s < QW; s++) begin
        if (adv[s]) vld_r[s] <= vld_r[s-1];
      end
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = vld_r[QW-1];

  logic [DW-1:0]  rem_r [QW][LANES];
  logic [QW-1:0]  low_r [QW][LANES];
  logic [QW-1:0]  quo_r [QW][LANES];
  logic [DW-1:0]  div_r [QW];
  logic [SBW-1:0] sb_r  [QW];

  for (genvar s = 0; s < QW; s++) begin : g_stg
    logic [DW-1:0]  rem_src [LANES];
    logic [QW-1:0]  low_src [LANES];
    logic [QW-1:0]  quo_src [LANES];
    logic [DW-1:0]  div_src;
    logic [SBW-1:0] sb_src;
    logic [DW:0]    trial   [LANES];
    logic [LANES-1:0] ge;

    // Operands come from the front end or from the previous stage
    if (s == 0) begin : g_first
      always_comb begin
        for (int l = 0; l < LANES; l++) begin
          rem_src[l] = rem_i[l];
          low_src[l] = low_i[l];
          quo_src[l] = '0;
        end
        div_src = div_i;
        sb_src  = sb_i;
      end
    end else begin : g_next
      always_comb begin
        for (int l = 0; l < LANES; l++) begin
          rem_src[l] = rem_r[s-1][l];
          low_src[l] = low_r[s-1][l];
          quo_src[l] = quo_r[s-1][l];
        end
        div_src = div_r[s-1];
        sb_src  = sb_r[s-1];
      end
    end

    // Shift in the next numerator bit, subtract when it fits
    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        trial[l] = {rem_src[l], low_src[l][QW-1]};
        ge[l]    = trial[l] >= {1'b0, div_src};
      end
    end

    always_ff @(posedge clk) begin
      if (adv[s]) begin
        for (int l = 0; l < LANES; l++) begin
          rem_r[s][l] <= ge[l] ? DW'(trial[l] - {1'b0, div_src}) : DW'(trial[l]);
          low_r[s][l] <= low_src[l] << 1;
          quo_r[s][l] <= {quo_src[l][QW-2:0], ge[l]};
        end
        div_r[s] <= div_src;
        sb_r[s]  <= sb_src;
      end
    end
  end

  assign quo_o = quo_r[QW-1];
  assign sb_o  = sb_r[QW-1];

endmodule

// ===== hw/rtl/vara_back.sv =====
`timescale 1ns / 1ps

// Back end: I + K + term per element, saturation, output register.
module vara_back #(
  parameter int FRAC_BITS = 14,
  parameter int KW        = 19,
  parameter int QW        = 22,
  parameter int SBW       = 70
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [QW-1:0]                   quo_i [vara_pkg::LANES],
  input  logic [SBW-1:0]                  sb_i,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [vara_pkg::OUT_DATA_W-1:0] out_data,
  output logic                            out_sing
);
  import vara_pkg::*;

  localparam int AW = QW + 2;
  localparam logic signed [AW-1:0] ONE_Q = AW'(1) << FRAC_BITS;

  logic vld_r;

  assign in_ready  = !vld_r || out_ready;
  assign out_valid = vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  function automatic field_t sat(input logic signed [AW-1:0] v);
    if (v > AW'(SAT_MAX)) return SAT_MAX;
    if (v < AW'(SAT_MIN)) return SAT_MIN;
    return FIELD_W'(v);
  endfunction

  // Sideband fields
  logic signed [KW-1:0] k01, k02, k12;
  logic [LANES-1:0]     neg, ovf;
  logic                 sing;

  assign k01  = sb_i[KW-1:0];
  assign k02  = sb_i[2*KW-1:KW];
  assign k12  = sb_i[3*KW-1:2*KW];
  assign neg  = sb_i[3*KW+LANES-1:3*KW];
  assign ovf  = sb_i[3*KW+2*LANES-1:3*KW+LANES];
  assign sing = sb_i[3*KW+2*LANES];

  // Signed rounded quotient per lane; clamped where it overflowed, zero when singular
  logic signed [AW-1:0] term [LANES];
  logic [QW-1:0]        qv;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      qv      = ovf[l] ? {QW{1'b1}} : quo_i[l];
      term[l] = sing ? '0 : (neg[l] ? -AW'(qv) : AW'(qv));
    end
  end

  // Assemble the nine elements row by row
  logic signed [AW-1:0] acc [OUT_ELEMS];

  always_comb begin
    acc[0] = ONE_Q + term[L00];
    acc[1] = AW'(k01) + term[L01];
    acc[2] = AW'(k02) + term[L02];
    acc[3] = -AW'(k01) + term[L01];
    acc[4] = ONE_Q + term[L11];
    acc[5] = AW'(k12) + term[L12];
    acc[6] = -AW'(k02) + term[L02];
    acc[7] = -AW'(k12) + term[L12];
    acc[8] = ONE_Q + term[L22];
  end

  logic [OUT_DATA_W-1:0] data_r;
  logic                  sing_r;

  always_ff @(posedge clk) begin
    if (in_ready) begin
      for (int e = 0; e < OUT_ELEMS; e++) begin
        data_r[e*FIELD_W +: FIELD_W] <= sat(acc[e]);
      end
      sing_r <= sing;
    end
  end

  assign out_data = data_r;
  assign out_sing = sing_r;

endmodule

// ===== hw/rtl/vector_align_rotation_matrix_top.sv =====
`timescale 1ns / 1ps

// Channel | Dir | Bits | Fields, lowest bit first
// in_     | in  | 96   | ax, ay, az, bx, by_comp, bz (signed Q14, 16 bits each)
// out_    | out | 144  | r00 r01 r02 r10 r11 r12 r20 r21 r22 (signed Q14, 16 each)
//         |     | 1    | tuser: singular
//
// One vector pair per cycle sustained while out_tready is high; QW is the
// quotient width, one divider stage per bit.
// Synchronous active-low reset clears the stage valid bits only.
// A stalled output holds its beat; bubbles inside the pipe still fill, so
// new beats are taken until every stage holds one.
module vector_align_rotation_matrix_top #(
  parameter int FRAC_BITS = 14
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [vara_pkg::IN_DATA_W-1:0]  in_tdata,   // ax, ay, az, bx, by_comp, bz
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [vara_pkg::OUT_DATA_W-1:0] out_tdata,  // r00 .. r22, row by row
  output logic [0:0]                      out_tuser   // singular
);
  import vara_pkg::*;

  localparam int KW  = 33 - FRAC_BITS;
  localparam int DW  = ((2 * FRAC_BITS > 32) ? 2 * FRAC_BITS : 32) + 2;
  localparam int NA  = 2 * KW + FRAC_BITS + 3;
  localparam int NW  = (NA > DW + 1) ? NA : DW + 1;
  localparam int QA  = (34 - FRAC_BITS > FRAC_BITS) ? 34 - FRAC_BITS : FRAC_BITS;
  localparam int QW  = ((QA > 16) ? QA : 16) + 2;
  localparam int SBW = 3 * KW + 2 * LANES + 1;

  // Front end to divider
  logic           f_valid, f_ready;
  logic [DW-1:0]  f_rem [LANES];
  logic [QW-1:0]  f_low [LANES];
  logic [DW-1:0]  f_div;
  logic [SBW-1:0] f_sb;

  // Divider to back end
  logic           d_valid, d_ready;
  logic [QW-1:0]  d_quo [LANES];
  logic [SBW-1:0] d_sb;

  vara_front #(
    .FRAC_BITS (FRAC_BITS),
    .KW        (KW),
    .DW        (DW),
    .NW        (NW),
    .QW        (QW),
    .SBW       (SBW)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .ax        (in_tdata[15:0]),
    .ay        (in_tdata[31:16]),
    .az        (in_tdata[47:32]),
    .bx        (in_tdata[63:48]),
    .by_comp   (in_tdata[79:64]),
    .bz        (in_tdata[95:80]),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .rem_o     (f_rem),
    .low_o     (f_low),
    .div_o     (f_div),
    .sb_o      (f_sb)
  );

  vara_div #(
    .DW  (DW),
    .QW  (QW),
    .SBW (SBW)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .rem_i     (f_rem),
    .low_i     (f_low),
    .div_i     (f_div),
    .sb_i      (f_sb),
    .out_valid (d_valid),
    .out_ready (d_ready),
    .quo_o     (d_quo),
    .sb_o      (d_sb)
  );

  vara_back #(
    .FRAC_BITS (FRAC_BITS),
    .KW        (KW),
    .QW        (QW),
    .SBW       (SBW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (d_valid),
    .in_ready  (d_ready),
    .quo_i     (d_quo),
    .sb_i      (d_sb),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata),
    .out_sing  (out_tuser[0])
  );

endmodule
